/* sv/assert_macros.svh */
// ============================================================================
// Assertion macros
// Shared shorthand for clocked concurrent assertions with reset disable.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define PPS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scheduler assertion failed");

// A condition that must never be seen at a clock edge.
`define PPS_ASSERT_NEVER(label, cond) \
    `PPS_ASSERT(label, !(cond))

`endif

/* sv/pps_pkg.sv */
// ============================================================================
// Preemptive priority scheduler package
// Word types, task table entry type, function codes and default sizes.
// ============================================================================
package pps_pkg;

    // Default sizes for the top level parameters.
    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    // Function codes of an input word.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Input word.
    typedef struct packed {
        logic        func;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  priority_req;
    } item_word_t;

    // Result word.
    typedef struct packed {
        logic        load_rejected;
        logic        idle;
        logic [3:0]  running_slot;
        logic        switched;
        logic        finished;
        logic [15:0] finish_time;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic        all_done;
    } result_word_t;

    // One task slot as held in the task memory.
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic [7:0]  prio;
    } task_entry_t;

    // Best candidate found by the scan.
    typedef struct packed {
        logic        found;
        task_entry_t entry;
    } pick_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_PUSH
    } pps_state_t;

endpackage

/* sv/pps_pick.sv */
// ============================================================================
// Candidate selector
// Compares one task entry per cycle against the best ready task so far and
// keeps the winner: lowest priority value, earliest slot on ties.
// ============================================================================
module pps_pick #(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         cmp_en,
    input  logic [$clog2(MAX_TASKS)-1:0] slot_idx,
    input  pps_pkg::task_entry_t         entry,
    input  logic [TIME_BITS-1:0]         now,
    output pps_pkg::pick_t               pick,
    output logic [$clog2(MAX_TASKS)-1:0] best_slot
);
    import pps_pkg::*;

    localparam int SLOT_BITS = $clog2(MAX_TASKS);
    localparam int CMP_BITS  = (TIME_BITS > 16) ? TIME_BITS : 16;

    logic                 found_reg;
    task_entry_t          entry_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic                 arrived;
    logic                 better;

    // A task is a candidate when it has arrived and still has work left.
    // Strictly lower priority is needed to replace, so earlier slots win ties.
    always_comb
    begin
        arrived = CMP_BITS'(entry.arrival) <= CMP_BITS'(now);
        better  = arrived && (entry.remaining != 16'd0) &&
                  (!found_reg || (entry.prio < entry_reg.prio));
    end

    // Found flag is control state and is cleared at the start of each scan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (cmp_en && better)
        begin
            found_reg <= 1'b1;
        end
    end

    // Winner payload.
    always_ff @(posedge clk)
    begin
        if (cmp_en && better)
        begin
            entry_reg <= entry;
            slot_reg  <= slot_idx;
        end
    end

    assign pick.found  = found_reg;
    assign pick.entry  = entry_reg;
    assign best_slot   = slot_reg;

endmodule

/* sv/preemptive_priority_scheduler_top.sv */
// ============================================================================
// Preemptive priority scheduler
// Task table in one synchronous memory, scanned one slot per cycle per tick.
// ============================================================================
// A load word goes from acceptance through the push state back to idle. A
// tick word goes through the scan, update and push states: the task memory
// has one read port, so the scan reads the loaded slots one slot per cycle,
// then the update writes the chosen slot and the counters, and push hands the
// word to the output register once it is free. A word waiting in the output
// register does not stop the next input word from being accepted.
// ============================================================================
module preemptive_priority_scheduler_top #(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  pps_pkg::item_word_t   item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output pps_pkg::result_word_t result
);
    import pps_pkg::*;

    localparam int SLOT_BITS = $clog2(MAX_TASKS);
    localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);
    localparam int CMP_BITS  = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam int SLOT_W4   = (SLOT_BITS > 4) ? SLOT_BITS : 4;

    // Saturate a time value to the 16-bit output range.
    function automatic logic [15:0] sat16(input logic [CMP_BITS-1:0] v);
        logic [15:0] r;
        r = (v > CMP_BITS'(16'hFFFF)) ? 16'hFFFF : v[15:0];
        return r;
    endfunction

    // Control state.
    pps_state_t           state_reg, state_next;
    logic [CNT_BITS-1:0]  loaded_count_reg, loaded_count_next;
    logic [CNT_BITS-1:0]  done_count_reg, done_count_next;
    logic [TIME_BITS-1:0] current_time_reg, current_time_next;
    logic                 has_last_reg, has_last_next;
    logic                 last_idle_reg, last_idle_next;
    logic [SLOT_BITS-1:0] last_slot_reg, last_slot_next;
    logic [SLOT_BITS-1:0] scan_idx_reg, scan_idx_next;
    logic                 result_valid_reg, result_valid_next;

    // Payload.
    result_word_t         pend_reg, pend_next;
    result_word_t         result_reg;

    // Task memory.
    task_entry_t          task_mem [MAX_TASKS];
    task_entry_t          rd_data_reg;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    task_entry_t          wr_data;

    // Selector interface.
    logic                 pick_clear;
    logic                 pick_en;
    pick_t                pick;
    logic [SLOT_BITS-1:0] best_slot;

    // Helpers.
    logic                 item_fire;
    logic                 out_free;
    logic                 scan_last;
    logic                 table_full;
    logic [TIME_BITS-1:0] time_after;
    logic [15:0]          rem_after;
    logic [CMP_BITS-1:0]  tat;
    logic [SLOT_W4-1:0]   slot_ext;

    assign item_ready = (state_reg == ST_IDLE);
    assign item_fire  = item_valid && item_ready;
    assign out_free   = !result_valid_reg || result_ready;
    assign scan_last  = (CNT_BITS'(scan_idx_reg) + CNT_BITS'(1)) == loaded_count_reg;
    assign table_full = loaded_count_reg >= CNT_BITS'(MAX_TASKS);

    // Task memory: one write port, one registered read port. Loads write at
    // acceptance and the update writes after the scan, so no read of a slot
    // overlaps a pending write to it.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            task_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= task_mem[rd_addr];
    end

    // Selector of the best ready task.
    pps_pick #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (pick_clear),
        .cmp_en    (pick_en),
        .slot_idx  (scan_idx_reg),
        .entry     (rd_data_reg),
        .now       (current_time_reg),
        .pick      (pick),
        .best_slot (best_slot)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (item.func == FUNC_LOAD)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if (loaded_count_reg == '0)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Arithmetic of the update step.
    always_comb
    begin
        time_after = (current_time_reg != {TIME_BITS{1'b1}}) ?
                     current_time_reg + TIME_BITS'(1) : current_time_reg;
        rem_after  = pick.entry.remaining - 16'd1;
        tat        = CMP_BITS'(time_after) - CMP_BITS'(pick.entry.arrival);
        slot_ext   = SLOT_W4'(best_slot);
    end

    // Datapath and memory control.
    always_comb
    begin
        loaded_count_next = loaded_count_reg;
        done_count_next   = done_count_reg;
        current_time_next = current_time_reg;
        has_last_next     = has_last_reg;
        last_idle_next    = last_idle_reg;
        last_slot_next    = last_slot_reg;
        scan_idx_next     = scan_idx_reg;
        result_valid_next = result_valid_reg;
        pend_next         = pend_reg;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = loaded_count_reg[SLOT_BITS-1:0];
        wr_data           = '0;
        pick_clear        = 1'b0;
        pick_en           = 1'b0;

        // Output register drains independently of the sequencer.
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    pend_next             = '0;
                    pend_next.finish_time = sat16(CMP_BITS'(current_time_reg));
                    if (item.func == FUNC_LOAD)
                    begin
                        if (table_full)
                        begin
                            pend_next.load_rejected = 1'b1;
                            pend_next.all_done      = done_count_reg >= loaded_count_reg;
                        end
                        else
                        begin
                            wr_en             = 1'b1;
                            wr_data.arrival   = item.arrival;
                            wr_data.burst     = item.burst;
                            wr_data.remaining = item.burst;
                            wr_data.prio      = item.priority_req;
                            loaded_count_next = loaded_count_reg + CNT_BITS'(1);
                            if (item.burst == 16'd0)
                            begin
                                done_count_next = done_count_reg + CNT_BITS'(1);
                            end
                            pend_next.all_done = done_count_next >= loaded_count_next;
                        end
                    end
                    else
                    begin
                        // Start the scan at slot zero.
                        pick_clear    = 1'b1;
                        scan_idx_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                pick_en       = 1'b1;
                scan_idx_next = scan_idx_reg + SLOT_BITS'(1);
                rd_addr       = scan_idx_next;
            end
            ST_UPDATE:
            begin
                current_time_next     = time_after;
                has_last_next         = 1'b1;
                pend_next             = '0;
                pend_next.finish_time = sat16(CMP_BITS'(time_after));
                if (!pick.found)
                begin
                    pend_next.idle     = 1'b1;
                    pend_next.switched = !has_last_reg || !last_idle_reg;
                    last_idle_next     = 1'b1;
                    last_slot_next     = '0;
                end
                else
                begin
                    pend_next.running_slot = slot_ext[3:0];
                    pend_next.switched     = !has_last_reg || last_idle_reg ||
                                             (last_slot_reg != best_slot);
                    last_idle_next         = 1'b0;
                    last_slot_next         = best_slot;

                    // Write back the chosen slot with one unit less to run.
                    wr_en             = 1'b1;
                    wr_addr           = best_slot;
                    wr_data           = pick.entry;
                    wr_data.remaining = rem_after;

                    if (rem_after == 16'd0)
                    begin
                        done_count_next      = done_count_reg + CNT_BITS'(1);
                        pend_next.finished   = 1'b1;
                        pend_next.turnaround = sat16(tat);
                        pend_next.waiting    =
                            (tat >= CMP_BITS'(pick.entry.burst)) ?
                            sat16(tat - CMP_BITS'(pick.entry.burst)) : 16'd0;
                    end
                end
                pend_next.all_done = done_count_next >= loaded_count_reg;
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
                pend_next = pend_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            loaded_count_reg <= '0;
            done_count_reg   <= '0;
            current_time_reg <= '0;
            has_last_reg     <= 1'b0;
            last_idle_reg    <= 1'b0;
            last_slot_reg    <= '0;
            scan_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            done_count_reg   <= done_count_next;
            current_time_reg <= current_time_next;
            has_last_reg     <= has_last_next;
            last_idle_reg    <= last_idle_next;
            last_slot_reg    <= last_slot_next;
            scan_idx_reg     <= scan_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (state_reg == ST_PUSH && out_free)
        begin
            result_reg <= pend_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* sv/pps_checker.sv */
// ============================================================================
// Scheduler port checker
// Watches the handshake and result channel of the scheduler top level for
// consistency.
// ============================================================================
`include "assert_macros.svh"

module pps_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input pps_pkg::result_word_t result
);

    // A stalled result word stays presented and unchanged.
    `PPS_ASSERT(a_result_hold,
                result_valid && !result_ready |=> result_valid && $stable(result))

    // An accepted input word closes the input for at least the next cycle.
    `PPS_ASSERT(a_input_busy,
                item_valid && item_ready |=> !item_ready)

    // An idle tick runs no slot and finishes nothing.
    `PPS_ASSERT_NEVER(a_idle_clean,
                      result_valid && result.idle &&
                      (result.finished || result.running_slot != 4'd0))

    // A rejected load neither switches nor finishes a task.
    `PPS_ASSERT_NEVER(a_reject_clean,
                      result_valid && result.load_rejected &&
                      (result.switched || result.finished || result.idle))

    // Turnaround and waiting appear only on completion, and waiting never
    // exceeds turnaround.
    `PPS_ASSERT(a_finish_times,
                result_valid |-> (result.finished ?
                                  (result.waiting <= result.turnaround) :
                                  (result.turnaround == 16'd0 && result.waiting == 16'd0)))

endmodule

bind preemptive_priority_scheduler_top pps_checker u_pps_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// Preemptive priority scheduler testbench
// Drives load and tick words into the scheduler with random gaps on both
// sides, predicts every result word from a local copy of the task table,
// and compares each result field by field against the oldest prediction.
// ============================================================================
module tb;

    import pps_pkg::*;

    localparam int          MAX_SLOTS        = MAX_TASKS_DEF;
    localparam int unsigned TIME_MAX         = 65535;
    localparam int          RANDOM_WORDS     = 1850;
    localparam int unsigned SINK_HOLD_CYCLES = 300;
    localparam int          WATCHDOG_LIMIT   = 3000;
    localparam int          SETTLE_CYCLES    = 40;
    localparam int unsigned FULL_TICKS       = 12;

    // What ran on the previous tick, as the switch flag sees it.
    typedef enum logic [1:0] {
        LAST_NONE,
        LAST_IDLE,
        LAST_SLOT
    } last_run_t;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_ready;
    item_word_t   item;
    logic         result_valid;
    logic         result_ready;
    result_word_t result;

    // Local copy of the scheduler state.
    logic [15:0]  tab_arrival [MAX_SLOTS];
    logic [15:0]  tab_burst   [MAX_SLOTS];
    logic [15:0]  tab_left    [MAX_SLOTS];
    logic [7:0]   tab_prio    [MAX_SLOTS];
    int unsigned  n_loaded   = 0;
    int unsigned  n_done     = 0;
    int unsigned  now_time   = 0;
    last_run_t    last_kind  = LAST_NONE;
    int unsigned  last_slot  = 0;

    result_word_t expected_q [$];
    int           mismatch_count = 0;
    int           stuck_cycles   = 0;
    bit           idling_on;
    bit           sink_hold_req;
    int unsigned  sink_stall = 0;

    preemptive_priority_scheduler_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply one accepted word to the local task table and return the result word.
    function automatic result_word_t schedule_word(input item_word_t w);
        result_word_t r;
        int unsigned  best_prio;
        int unsigned  pick;
        int unsigned  tat;
        int unsigned  i;
        bit           found;
        r = '0;
        if (w.func == FUNC_LOAD)
        begin
            if (n_loaded >= MAX_SLOTS)
            begin
                r.load_rejected = 1'b1;
            end
            else
            begin
                tab_arrival[n_loaded] = w.arrival;
                tab_burst[n_loaded]   = w.burst;
                tab_left[n_loaded]    = w.burst;
                tab_prio[n_loaded]    = w.priority_req;
                // A task with nothing to do is complete as soon as it is loaded.
                if (w.burst == 16'd0)
                    n_done++;
                n_loaded++;
            end
            r.finish_time = 16'(now_time);
        end
        else
        begin
            // Lowest priority value among ready tasks; the first slot wins ties.
            best_prio = 256;
            pick      = 0;
            found     = 1'b0;
            for (i = 0; i < n_loaded; i++)
            begin
                if (tab_arrival[i] <= now_time && tab_left[i] != 16'd0 &&
                    tab_prio[i] < best_prio)
                begin
                    best_prio = tab_prio[i];
                    pick      = i;
                    found     = 1'b1;
                end
            end
            if (!found)
            begin
                r.idle     = 1'b1;
                r.switched = (last_kind != LAST_IDLE);
                last_kind  = LAST_IDLE;
                last_slot  = 0;
            end
            else
            begin
                r.running_slot = 4'(pick);
                r.switched     = (last_kind != LAST_SLOT) || (last_slot != pick);
                last_kind      = LAST_SLOT;
                last_slot      = pick;
                tab_left[pick] = tab_left[pick] - 16'd1;
            end
            // Time stops at its top value.
            if (now_time < TIME_MAX)
                now_time++;
            r.finish_time = 16'(now_time);
            if (found && tab_left[pick] == 16'd0)
            begin
                n_done++;
                tat          = now_time - tab_arrival[pick];
                r.finished   = 1'b1;
                r.turnaround = 16'(tat);
                r.waiting    = (tat >= tab_burst[pick]) ? 16'(tat - tab_burst[pick]) : 16'd0;
            end
        end
        r.all_done = (n_done >= n_loaded);
        return r;
    endfunction

    function automatic void check_field(input string field_name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // Predict on every accepted input word, then check every accepted result word.
    always @(posedge clk)
    begin
        result_word_t exp_w;
        if (rst_n && item_valid && item_ready)
            expected_q.push_back(schedule_word(item));
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result word with none expected, actual %h", $time, result);
                mismatch_count++;
            end
            else
            begin
                exp_w = expected_q.pop_front();
                check_field("load_rejected", 16'(exp_w.load_rejected),
                            16'(result.load_rejected));
                check_field("idle", 16'(exp_w.idle), 16'(result.idle));
                check_field("running_slot", 16'(exp_w.running_slot),
                            16'(result.running_slot));
                check_field("switched", 16'(exp_w.switched), 16'(result.switched));
                check_field("finished", 16'(exp_w.finished), 16'(result.finished));
                check_field("finish_time", exp_w.finish_time, result.finish_time);
                check_field("turnaround", exp_w.turnaround, result.turnaround);
                check_field("waiting", exp_w.waiting, result.waiting);
                check_field("all_done", 16'(exp_w.all_done), 16'(result.all_done));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, stuck_cycles);
                $display("preemptive_priority_scheduler_top regression: fail");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Result sink: random stalls, plus a long hold-off on request.
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                sink_stall    = SINK_HOLD_CYCLES;
            end
            if (sink_stall > 0)
            begin
                result_ready <= 1'b0;
                sink_stall--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 99) < 20)
                    sink_stall = draw_gap();
            end
        end
    end

    // Offer one word from a falling edge, hold it until accepted, then idle
    // for a random gap. Returns on a falling edge.
    task automatic send_word(input item_word_t w);
        int unsigned gap;
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
        gap = idling_on ? draw_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop offering and wait on falling edges until every result word is in.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic item_word_t make_load(input logic [15:0] arr, input logic [15:0] bur,
                                             input logic [7:0] prio);
        item_word_t w;
        w.func         = FUNC_LOAD;
        w.arrival      = arr;
        w.burst        = bur;
        w.priority_req = prio;
        return w;
    endfunction

    // Tick words carry random payload, which the block ignores.
    function automatic item_word_t make_tick();
        item_word_t w;
        w.func         = FUNC_TICK;
        w.arrival      = 16'($urandom_range(0, 65535));
        w.burst        = 16'($urandom_range(0, 65535));
        w.priority_req = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // Ticks on an empty table: idle, switch only on the first one, all done.
    task automatic test_empty_ticks();
        send_word(make_tick());
        send_word(make_tick());
        wait_drained();
    endtask

    // A zero-length task is complete at load and never runs.
    task automatic test_zero_burst();
        send_word(make_load(16'd0, 16'd0, 8'd7));
        send_word(make_tick());
        wait_drained();
    endtask

    // A task that arrives later: idle ticks first, then it runs to the end.
    task automatic test_future_arrival();
        int unsigned k;
        send_word(make_load(16'(now_time + 3), 16'd2, 8'd255));
        for (k = 0; k < 5; k++)
            send_word(make_tick());
        wait_drained();
    endtask

    // A more urgent task takes over, then the first resumes; equal priorities
    // go to the lower slot.
    task automatic test_preemption();
        send_word(make_load(16'(now_time), 16'd4, 8'd10));
        send_word(make_tick());
        send_word(make_tick());
        send_word(make_load(16'd0, 16'd2, 8'd0));
        repeat (4) send_word(make_tick());
        send_word(make_load(16'd0, 16'd1, 8'd3));
        send_word(make_load(16'd0, 16'd1, 8'd3));
        repeat (2) send_word(make_tick());
        wait_drained();
    endtask

    // Sink holds off while ticks keep coming, so the block stalls its input.
    task automatic test_back_pressure();
        idling_on     = 1'b0;
        sink_hold_req = 1'b1;
        repeat (10) send_word(make_tick());
        wait_drained();
        idling_on = 1'b1;
    endtask

    // Mostly ticks with the odd random load; one slot is kept for the end.
    task automatic test_random_traffic();
        int          n;
        int unsigned slots_free;
        int unsigned roll;
        logic [15:0] arr;
        logic [15:0] bur;
        slots_free = MAX_SLOTS - n_loaded - 1;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            // Every third stretch of 200 words runs without idling.
            idling_on = ((n / 200) % 3 != 2);
            if (slots_free > 0 && $urandom_range(0, 199) == 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    arr = 16'(now_time + $urandom_range(0, 30));
                else if (roll < 70)
                    arr = 16'($urandom_range(0, now_time));
                else
                    arr = 16'($urandom_range(0, 65535));
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    bur = 16'd0;
                else if (roll < 80)
                    bur = 16'($urandom_range(1, 150));
                else
                    bur = 16'($urandom_range(0, 65535));
                send_word(make_load(arr, bur, 8'($urandom_range(0, 255))));
                slots_free--;
            end
            else
            begin
                send_word(make_tick());
            end
        end
        wait_drained();
        idling_on = 1'b1;
    endtask

    // Fill the table, then offer loads that find it full between ticks that
    // keep the short tasks running.
    task automatic test_full_table();
        int unsigned slots_free;
        int unsigned k;
        slots_free = MAX_SLOTS - n_loaded;
        while (slots_free > 0)
        begin
            send_word(make_load(16'(now_time), 16'($urandom_range(1, 8)),
                                8'($urandom_range(0, 255))));
            slots_free--;
        end
        for (k = 0; k < FULL_TICKS; k++)
        begin
            if (k % 3 == 0)
                send_word(make_load(16'($urandom_range(0, 65535)),
                                    16'($urandom_range(0, 65535)),
                                    8'($urandom_range(0, 255))));
            send_word(make_tick());
        end
        wait_drained();
    endtask

    // Test sequence.
    initial
    begin
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        idling_on     = 1'b1;
        sink_hold_req = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_ticks();
        test_zero_burst();
        test_future_arrival();
        test_preemption();
        test_back_pressure();
        test_random_traffic();
        test_full_table();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("preemptive_priority_scheduler_top regression: pass");
        else
            $display("preemptive_priority_scheduler_top regression: fail");
        $finish;
    end

endmodule
